[rtl/core/pedd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette dither package
// Shared field widths, command and register codes, and the search control struct.
// ----------------------------------------------------------------------------
package pedd_pkg;

	localparam int COLOUR_BITS     = 8;
	localparam int RGB_BITS        = 3 * COLOUR_BITS;
	localparam int SLOT_BITS       = 8;
	localparam int INDEX_OUT_BITS  = 8;
	localparam int COLUMN_BITS     = 10;
	localparam int CFG_INDEX_BITS  = 1;
	localparam int CFG_DATA_BITS   = 11;
	localparam int COUNT_REG_BITS  = 9;

	// Input commands.
	localparam logic CMD_PALETTE = 1'b0;
	localparam logic CMD_PIXEL   = 1'b1;

	// Register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COLOUR_COUNT = 1'd1;

	// Register reset values.
	localparam logic [CFG_DATA_BITS-1:0]  WIDTH_RESET = 11'd1024;
	localparam logic [COUNT_REG_BITS-1:0] COUNT_RESET = 9'd256;

	// Control from the sequencer to the palette search unit.
	typedef struct packed {
		logic start;
		logic pal_we;
	} srch_ctl_t;

endpackage

[rtl/core/pedd_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel for palette writes and pixels.
// ----------------------------------------------------------------------------
interface pedd_in_if;
	import pedd_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   command;
	logic [SLOT_BITS-1:0]   palette_slot;
	logic [COLOUR_BITS-1:0] red;
	logic [COLOUR_BITS-1:0] green;
	logic [COLOUR_BITS-1:0] blue;
	logic                   frame_start;

	modport source (
		output valid, command, palette_slot, red, green, blue, frame_start,
		input  ready
	);

	modport sink (
		input  valid, command, palette_slot, red, green, blue, frame_start,
		output ready
	);

endinterface

[rtl/core/pedd_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one palette index per pixel.
// ----------------------------------------------------------------------------
interface pedd_out_if;
	import pedd_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [INDEX_OUT_BITS-1:0] colour_index;
	logic [COLUMN_BITS-1:0]    column;
	logic                      row_end;

	modport source (
		output valid, colour_index, column, row_end,
		input  ready
	);

	modport sink (
		input  valid, colour_index, column, row_end,
		output ready
	);

endinterface

[rtl/core/pedd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pedd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read; a read of the entry being written returns old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/pedd_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette search unit
// Holds the palette and scans it one entry a cycle for the nearest colour.
// ----------------------------------------------------------------------------
module pedd_search #(
	parameter int PALETTE_DEPTH = 256,
	parameter int ERROR_BITS    = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pedd_pkg::srch_ctl_t               ctl,
	input  logic [$clog2(PALETTE_DEPTH)-1:0]  pal_addr,
	input  logic [pedd_pkg::RGB_BITS-1:0]     pal_data,
	input  logic [$clog2(PALETTE_DEPTH):0]    count,
	input  logic signed [ERROR_BITS+1:0]      comp [3],
	output logic                              done,
	output logic [$clog2(PALETTE_DEPTH)-1:0]  best_idx,
	output logic [pedd_pkg::RGB_BITS-1:0]     best_rgb
);
	import pedd_pkg::*;

	localparam int IW = $clog2(PALETTE_DEPTH);
	localparam int EW = ERROR_BITS + 2;
	localparam int PW = 2 * EW;
	localparam int DW = PW + 2;

	logic          issuing_q;
	logic [IW:0]   addr_q;
	logic          issue_last;
	logic [RGB_BITS-1:0] pal_rdata;

	logic          v_s1, last_s1;
	logic [IW-1:0] idx_s1;
	logic          v_s2, last_s2;
	logic [IW-1:0] idx_s2;
	logic [RGB_BITS-1:0] rgb_s2;
	logic [PW-1:0] sq_s2 [3];

	logic          first_q;
	logic          done_q;
	logic [DW-1:0] best_d_q;
	logic [IW-1:0] best_idx_q;
	logic [RGB_BITS-1:0] best_rgb_q;

	logic signed [EW-1:0] diff [3];
	logic signed [PW-1:0] prod [3];
	logic [DW-1:0]        dsum;
	logic                 better;

	pedd_ram #(.WIDTH(RGB_BITS), .DEPTH(PALETTE_DEPTH)) u_palette (
		.clk   (clk),
		.we    (ctl.pal_we),
		.waddr (pal_addr),
		.wdata (pal_data),
		.raddr (addr_q[IW-1:0]),
		.rdata (pal_rdata)
	);

	assign issue_last = ((addr_q + (IW+1)'(1)) == count);

	// Distance terms for the entry that the RAM returns this cycle.
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			diff[ch] = comp[ch]
				- EW'($signed({1'b0, pal_rdata[(2-ch)*COLOUR_BITS +: COLOUR_BITS]}));
			prod[ch] = PW'(diff[ch]) * PW'(diff[ch]);
		end
	end

	// Sum of squares and compare; the lowest index wins a tie.
	assign dsum   = DW'(sq_s2[0]) + DW'(sq_s2[1]) + DW'(sq_s2[2]);
	assign better = first_q || (dsum < best_d_q);

	// Address sequencing and pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			addr_q    <= '0;
			v_s1      <= 1'b0;
			last_s1   <= 1'b0;
			v_s2      <= 1'b0;
			last_s2   <= 1'b0;
			first_q   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (ctl.start) begin
				issuing_q <= 1'b1;
				addr_q    <= '0;
			end else if (issuing_q) begin
				addr_q <= addr_q + (IW+1)'(1);
				if (issue_last) begin
					issuing_q <= 1'b0;
				end
			end
			v_s1    <= issuing_q && !ctl.start;
			last_s1 <= issue_last;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			if (ctl.start) begin
				first_q <= 1'b1;
			end else if (v_s2) begin
				first_q <= 1'b0;
			end
			done_q <= v_s2 && last_s2;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q[IW-1:0];
		idx_s2 <= idx_s1;
		rgb_s2 <= pal_rdata;
		for (int ch = 0; ch < 3; ch++) begin
			sq_s2[ch] <= prod[ch];
		end
		if (v_s2 && better) begin
			best_d_q   <= dsum;
			best_idx_q <= idx_s2;
			best_rgb_q <= rgb_s2;
		end
	end

	assign done     = done_q;
	assign best_idx = best_idx_q;
	assign best_rgb = best_rgb_q;

endmodule

[rtl/core/palette_error_diffusion_dither.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette error diffusion dither
// Serpentine Floyd-Steinberg quantizer to a loaded palette, with the two
// error rows held in one RAM and updated by read-modify-write.
// ----------------------------------------------------------------------------
// A pixel reads its error entry, runs the palette scan, one entry per cycle, and then
// makes its read-modify-write error updates before its result is offered.
// A pixel that ends a row adds a clearing sweep of that row over the columns
// touched since its last clear; a frame start sweeps both rows the same way.
// After reset both rows are swept over all MAX_WIDTH columns before the first
// item is accepted; configuration writes are taken at any time.
module palette_error_diffusion_dither #(
	parameter int MAX_WIDTH     = 1024,
	parameter int PALETTE_DEPTH = 256,
	parameter int ERROR_BITS    = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pedd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [pedd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	pedd_in_if.sink                             pixels,
	pedd_out_if.source                          results
);
	import pedd_pkg::*;

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int IW    = $clog2(PALETTE_DEPTH);
	localparam int NW    = IW + 1;
	localparam int EW    = ERROR_BITS + 2;
	localparam int SW    = EW + 4;
	localparam int AW    = $clog2(2 * MAX_WIDTH);
	localparam int EWORD = 3 * ERROR_BITS;

	localparam logic signed [SW:0] SAT_HI = (SW+1)'((2 ** (ERROR_BITS - 1)) - 1);
	localparam logic signed [SW:0] SAT_LO = (SW+1)'(-(2 ** (ERROR_BITS - 1)));

	typedef enum logic [3:0] {
		S_SWEEP, S_IDLE, S_RDERR, S_COMP, S_SEARCH, S_SPLIT, S_UPD_RD, S_UPD_WR, S_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_SEVEN, OP_ONE, OP_THREE, OP_FIVE
	} upd_op_t;

	function automatic logic [AW-1:0] err_addr(input logic row, input logic [XW-1:0] col);
		logic [AW-1:0] base;
		base = row ? AW'(MAX_WIDTH) : '0;
		return base + AW'(col);
	endfunction

	function automatic logic [ERROR_BITS-1:0] sat_add(
		input logic [ERROR_BITS-1:0] prev,
		input logic signed [SW-1:0]  delta
	);
		logic signed [SW:0] s;
		s = (SW+1)'($signed(prev)) + (SW+1)'(delta);
		if (s > SAT_HI) begin
			s = SAT_HI;
		end else if (s < SAT_LO) begin
			s = SAT_LO;
		end
		return ERROR_BITS'(s);
	endfunction

	// Control state.
	state_t                   state_q;
	upd_op_t                  op_q;
	logic [CFG_DATA_BITS-1:0] width_q;
	logic [COUNT_REG_BITS-1:0] count_q;
	logic                     rev_q, cur_q;
	logic [XW-1:0]            pd_q;
	logic [1:0]               sweep_mask_q;
	logic [XW-1:0]            sw_col_q;
	logic                     pend_q;
	logic [WW-1:0]            hi_q [2];
	logic                     srch_start_q;
	logic                     out_valid_q;
	logic [INDEX_OUT_BITS-1:0] out_index_q;
	logic [COLUMN_BITS-1:0]   out_column_q;
	logic                     out_row_end_q;

	// Pixel datapath.
	logic [RGB_BITS-1:0]  pix_q;
	logic [XW-1:0]        x_q, fwd_q, back_q;
	logic                 has_fwd_q, has_back_q, row_end_q;
	logic signed [EW-1:0] comp_q [3];
	logic signed [EW-1:0] comp_c [3];
	logic signed [SW-1:0] e_c [3];
	logic signed [SW-1:0] s7_c [3], s5_c [3], s3_c [3];
	logic signed [SW-1:0] sh7_q [3], sh5_q [3], sh3_q [3], sh1_q [3];

	logic [WW-1:0] w_eff, w_last;
	logic [NW-1:0] n_eff;
	logic [XW-1:0] pd_c, x_c;
	logic          row_end_c, has_fwd_c, has_back_c;

	logic             op_row, op_en;
	logic [XW-1:0]    op_col;
	logic signed [SW-1:0] delta [3];
	logic [EWORD-1:0] upd_word;

	logic             sw_row, sw_finish;
	logic             err_we;
	logic [AW-1:0]    err_waddr, err_raddr;
	logic [EWORD-1:0] err_wdata, err_rdata;

	logic          pix_acc;
	srch_ctl_t     srch_ctl;
	logic          srch_done;
	logic [IW-1:0] best_idx;
	logic [RGB_BITS-1:0] best_rgb;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q <= cfg_data;
				REG_COLOUR_COUNT: count_q <= COUNT_REG_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	// Clamped width and colour count.
	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (count_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(count_q) > PALETTE_DEPTH) begin
			n_eff = NW'(PALETTE_DEPTH);
		end else begin
			n_eff = NW'(count_q);
		end
	end

	// Scan position of the pixel about to be processed.
	always_comb begin
		w_last = w_eff - WW'(1);
		pd_c   = (WW'(pd_q) > w_last) ? XW'(w_last) : pd_q;
		x_c    = rev_q ? XW'(w_last - WW'(pd_c)) : pd_c;
		row_end_c  = (WW'(pd_c) + WW'(1)) >= w_eff;
		has_fwd_c  = rev_q ? (x_c != '0) : ((WW'(x_c) + WW'(1)) < w_eff);
		has_back_c = rev_q ? ((WW'(x_c) + WW'(1)) < w_eff) : (x_c != '0);
	end

	// Error-compensated pixel and the diffusion shares, rounded half up.
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			comp_c[ch] = EW'($signed({1'b0, pix_q[(2-ch)*COLOUR_BITS +: COLOUR_BITS]}))
				+ EW'($signed(err_rdata[(2-ch)*ERROR_BITS +: ERROR_BITS]));
			e_c[ch] = SW'(comp_q[ch])
				- SW'($signed({1'b0, best_rgb[(2-ch)*COLOUR_BITS +: COLOUR_BITS]}));
			s7_c[ch] = SW'((e_c[ch] * 7 + 8) >>> 4);
			s5_c[ch] = SW'((e_c[ch] * 5 + 8) >>> 4);
			s3_c[ch] = SW'((e_c[ch] * 3 + 8) >>> 4);
		end
	end

	// Target entry and share of the current update step.
	always_comb begin
		case (op_q)
			OP_SEVEN: begin
				op_row = cur_q;  op_col = fwd_q;  op_en = has_fwd_q;
			end
			OP_ONE: begin
				op_row = !cur_q; op_col = fwd_q;  op_en = has_fwd_q;
			end
			OP_THREE: begin
				op_row = !cur_q; op_col = back_q; op_en = has_back_q;
			end
			default: begin
				op_row = !cur_q; op_col = x_q;    op_en = 1'b1;
			end
		endcase
		for (int ch = 0; ch < 3; ch++) begin
			case (op_q)
				OP_SEVEN: delta[ch] = sh7_q[ch];
				OP_ONE:   delta[ch] = sh1_q[ch];
				OP_THREE: delta[ch] = sh3_q[ch];
				default:  delta[ch] = sh5_q[ch];
			endcase
			upd_word[(2-ch)*ERROR_BITS +: ERROR_BITS] =
				sat_add(err_rdata[(2-ch)*ERROR_BITS +: ERROR_BITS], delta[ch]);
		end
	end

	// Clearing sweep: lower pending row first, only the columns it holds.
	assign sw_row    = !sweep_mask_q[0];
	assign sw_finish = (hi_q[sw_row] == '0) || ((WW'(sw_col_q) + WW'(1)) >= hi_q[sw_row]);

	// Error RAM ports.
	always_comb begin
		err_we    = 1'b0;
		err_waddr = err_addr(op_row, op_col);
		err_wdata = upd_word;
		if (state_q == S_SWEEP) begin
			err_we    = (hi_q[sw_row] != '0);
			err_waddr = err_addr(sw_row, sw_col_q);
			err_wdata = '0;
		end else if (state_q == S_UPD_WR) begin
			err_we = 1'b1;
		end
		err_raddr = (state_q == S_RDERR) ? err_addr(cur_q, x_c) : err_addr(op_row, op_col);
	end

	pedd_ram #(.WIDTH(EWORD), .DEPTH(2 * MAX_WIDTH)) u_err_rows (
		.clk   (clk),
		.we    (err_we),
		.waddr (err_waddr),
		.wdata (err_wdata),
		.raddr (err_raddr),
		.rdata (err_rdata)
	);

	// Input handshake and palette writes.
	assign pixels.ready = (state_q == S_IDLE);
	assign pix_acc      = pixels.valid && pixels.ready && (pixels.command == CMD_PIXEL);

	assign srch_ctl.start  = srch_start_q;
	assign srch_ctl.pal_we = pixels.valid && pixels.ready && (pixels.command == CMD_PALETTE)
		&& (32'(pixels.palette_slot) < PALETTE_DEPTH);

	pedd_search #(.PALETTE_DEPTH(PALETTE_DEPTH), .ERROR_BITS(ERROR_BITS)) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (srch_ctl),
		.pal_addr (IW'(pixels.palette_slot)),
		.pal_data ({pixels.red, pixels.green, pixels.blue}),
		.count    (n_eff),
		.comp     (comp_q),
		.done     (srch_done),
		.best_idx (best_idx),
		.best_rgb (best_rgb)
	);

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_SWEEP;
			op_q          <= OP_SEVEN;
			rev_q         <= 1'b0;
			cur_q         <= 1'b0;
			pd_q          <= '0;
			sweep_mask_q  <= 2'b11;
			sw_col_q      <= '0;
			pend_q        <= 1'b0;
			hi_q[0]       <= WW'(MAX_WIDTH);
			hi_q[1]       <= WW'(MAX_WIDTH);
			srch_start_q  <= 1'b0;
			out_valid_q   <= 1'b0;
			out_index_q   <= '0;
			out_column_q  <= '0;
			out_row_end_q <= 1'b0;
		end else begin
			srch_start_q <= (state_q == S_COMP);
			if (results.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_SWEEP: begin
					if (sw_finish) begin
						hi_q[sw_row]         <= '0;
						sweep_mask_q[sw_row] <= 1'b0;
						sw_col_q             <= '0;
						if (sw_row || !sweep_mask_q[1]) begin
							state_q <= pend_q ? S_RDERR : S_IDLE;
							pend_q  <= 1'b0;
						end
					end else begin
						sw_col_q <= sw_col_q + XW'(1);
					end
				end
				S_IDLE: begin
					if (pix_acc) begin
						if (pixels.frame_start) begin
							rev_q        <= 1'b0;
							cur_q        <= 1'b0;
							pd_q         <= '0;
							sweep_mask_q <= 2'b11;
							pend_q       <= 1'b1;
							state_q      <= S_SWEEP;
						end else begin
							state_q <= S_RDERR;
						end
					end
				end
				S_RDERR: begin
					pd_q    <= pd_c;
					state_q <= S_COMP;
				end
				S_COMP: begin
					state_q <= S_SEARCH;
				end
				S_SEARCH: begin
					if (srch_done) begin
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					op_q    <= OP_SEVEN;
					state_q <= S_UPD_RD;
				end
				S_UPD_RD, S_UPD_WR: begin
					if (state_q == S_UPD_RD && op_en) begin
						state_q <= S_UPD_WR;
					end else begin
						if (state_q == S_UPD_WR && (WW'(op_col) + WW'(1)) > hi_q[op_row]) begin
							hi_q[op_row] <= WW'(op_col) + WW'(1);
						end
						if (op_q == OP_FIVE) begin
							state_q <= S_DONE;
						end else begin
							op_q    <= upd_op_t'(op_q + 2'd1);
							state_q <= S_UPD_RD;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || results.ready) begin
						out_valid_q   <= 1'b1;
						out_index_q   <= INDEX_OUT_BITS'(best_idx);
						out_column_q  <= COLUMN_BITS'(x_q);
						out_row_end_q <= row_end_q;
						if (row_end_q) begin
							cur_q        <= !cur_q;
							rev_q        <= !rev_q;
							pd_q         <= '0;
							sweep_mask_q <= cur_q ? 2'b10 : 2'b01;
							state_q      <= S_SWEEP;
						end else begin
							pd_q    <= pd_q + XW'(1);
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Pixel datapath registers.
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			pix_q <= {pixels.red, pixels.green, pixels.blue};
		end
		if (state_q == S_RDERR) begin
			x_q        <= x_c;
			fwd_q      <= rev_q ? (x_c - XW'(1)) : (x_c + XW'(1));
			back_q     <= rev_q ? (x_c + XW'(1)) : (x_c - XW'(1));
			has_fwd_q  <= has_fwd_c;
			has_back_q <= has_back_c;
			row_end_q  <= row_end_c;
		end
		for (int ch = 0; ch < 3; ch++) begin
			if (state_q == S_COMP) begin
				comp_q[ch] <= comp_c[ch];
			end
			if (state_q == S_SPLIT) begin
				sh7_q[ch] <= s7_c[ch];
				sh5_q[ch] <= s5_c[ch];
				sh3_q[ch] <= s3_c[ch];
				sh1_q[ch] <= e_c[ch] - s7_c[ch] - s5_c[ch] - s3_c[ch];
			end
		end
	end

	assign results.valid        = out_valid_q;
	assign results.colour_index = out_index_q;
	assign results.column       = out_column_q;
	assign results.row_end      = out_row_end_q;

	// The search unit reports completion only to a waiting sequencer.
	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		srch_done |-> state_q == S_SEARCH)
		else $error("search completion outside the search state");

	// A sweep always has a row left to clear.
	a_sweep_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SWEEP |-> sweep_mask_q != 2'b00)
		else $error("sweep state with no row pending");

	// No item enters while a row clear is still owed.
	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && pixels.ready) |-> sweep_mask_q == 2'b00)
		else $error("item accepted before error rows were cleared");

	// Written extents never pass the row length.
	a_extent_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(hi_q[0]) <= MAX_WIDTH) && (32'(hi_q[1]) <= MAX_WIDTH))
		else $error("error row extent beyond row length");

endmodule

[tb/dither_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dither result checker
// Watches the pixel, result and register ports, predicts the palette index,
// column and row end of every pixel, and compares each result beat in order.
// ----------------------------------------------------------------------------
module dither_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pedd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [pedd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	pedd_in_if                                  pix_ch,
	pedd_out_if                                 res_ch,
	output int                                  fail_count,
	output int                                  pending
);
	import pedd_pkg::*;

	localparam int ROW_LEN   = 1024;
	localparam int SLOTS     = 256;
	localparam int ERR_MAX   = 32767;
	localparam int ERR_MIN   = -32768;

	typedef struct packed {
		logic [INDEX_OUT_BITS-1:0] colour_index;
		logic [COLUMN_BITS-1:0]    column;
		logic                      row_end;
	} pixel_result_t;

	logic [RGB_BITS-1:0]       palette_mem [SLOTS];
	int                        err_mem [2][3][ROW_LEN];
	logic [CFG_DATA_BITS-1:0]  width_reg;
	logic [COUNT_REG_BITS-1:0] count_reg;
	int                        done_in_row;
	bit                        reverse;
	bit                        cur_row;
	pixel_result_t             expected_q [$];

	// Print one line per mismatch and count it.
	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic int sat_add(input int old_val, input int delta);
		int s;
		s = old_val + delta;
		if (s > ERR_MAX) s = ERR_MAX;
		if (s < ERR_MIN) s = ERR_MIN;
		return s;
	endfunction

	task automatic clear_row(input bit r);
		for (int ch = 0; ch < 3; ch++)
			for (int c = 0; c < ROW_LEN; c++)
				err_mem[r][ch][c] = 0;
	endtask

	// Quantize one pixel and diffuse its error along the serpentine scan.
	task automatic dither_pixel(input logic [7:0] r, g, b, input logic fs);
		int w, n, pd, x, best, e, s7, s5, s3, s1, fwd, back;
		int comp [3];
		int pix [3];
		longint d, best_d, diff;
		bit fwd_ok, back_ok, nxt;
		pixel_result_t res;
		pix[0] = r;
		pix[1] = g;
		pix[2] = b;
		if (fs) begin
			clear_row(0);
			clear_row(1);
			done_in_row = 0;
			reverse = 0;
			cur_row = 0;
		end
		w = width_reg;
		if (w < 1) w = 1;
		if (w > ROW_LEN) w = ROW_LEN;
		n = count_reg;
		if (n < 1) n = 1;
		if (n > SLOTS) n = SLOTS;
		pd = done_in_row;
		if (pd > w - 1) pd = w - 1;
		x = reverse ? (w - 1 - pd) : pd;
		nxt = ~cur_row;
		for (int ch = 0; ch < 3; ch++)
			comp[ch] = pix[ch] + err_mem[cur_row][ch][x];

		// Nearest entry by squared distance; the lowest index wins a tie.
		best = 0;
		best_d = 0;
		for (int i = 0; i < n; i++) begin
			d = 0;
			for (int ch = 0; ch < 3; ch++) begin
				diff = comp[ch] - int'(palette_mem[i][23 - 8 * ch -: 8]);
				d += diff * diff;
			end
			if (i == 0 || d < best_d) begin
				best_d = d;
				best = i;
			end
		end

		fwd_ok = reverse ? (x > 0) : (x + 1 < w);
		back_ok = reverse ? (x + 1 < w) : (x > 0);
		fwd = reverse ? x - 1 : x + 1;
		back = reverse ? x + 1 : x - 1;
		for (int ch = 0; ch < 3; ch++) begin
			e = comp[ch] - int'(palette_mem[best][23 - 8 * ch -: 8]);
			s7 = (e * 7 + 8) >>> 4;
			s5 = (e * 5 + 8) >>> 4;
			s3 = (e * 3 + 8) >>> 4;
			s1 = e - s7 - s5 - s3;
			if (fwd_ok) begin
				err_mem[cur_row][ch][fwd] = sat_add(err_mem[cur_row][ch][fwd], s7);
				err_mem[nxt][ch][fwd] = sat_add(err_mem[nxt][ch][fwd], s1);
			end
			if (back_ok)
				err_mem[nxt][ch][back] = sat_add(err_mem[nxt][ch][back], s3);
			err_mem[nxt][ch][x] = sat_add(err_mem[nxt][ch][x], s5);
		end

		res.colour_index = best[7:0];
		res.column = x[9:0];
		res.row_end = (pd + 1 >= w);
		if (res.row_end) begin
			clear_row(cur_row);
			cur_row = nxt;
			reverse = ~reverse;
			done_in_row = 0;
		end else begin
			done_in_row = pd + 1;
		end
		expected_q.push_back(res);
	endtask

	// Track registers and beats on every edge.
	always @(posedge clk or negedge arst_n) begin
		pixel_result_t want;
		if (!arst_n) begin
			clear_row(0);
			clear_row(1);
			width_reg = WIDTH_RESET;
			count_reg = COUNT_RESET;
			done_in_row = 0;
			reverse = 0;
			cur_row = 0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: begin
						width_reg = cfg_data;
					end
					REG_COLOUR_COUNT: begin
						count_reg = cfg_data[COUNT_REG_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (pix_ch.valid && pix_ch.ready) begin
				if (pix_ch.command == CMD_PALETTE)
					palette_mem[pix_ch.palette_slot] = {pix_ch.red, pix_ch.green, pix_ch.blue};
				else
					dither_pixel(pix_ch.red, pix_ch.green, pix_ch.blue, pix_ch.frame_start);
			end
			if (res_ch.valid && res_ch.ready) begin
				if (expected_q.size() == 0) begin
					report("result beat with no pixel waiting");
				end else begin
					want = expected_q.pop_front();
					if (res_ch.colour_index !== want.colour_index)
						report($sformatf("colour_index %0d, want %0d",
							res_ch.colour_index, want.colour_index));
					if (res_ch.column !== want.column)
						report($sformatf("column %0d, want %0d", res_ch.column, want.column));
					if (res_ch.row_end !== want.row_end)
						report($sformatf("row_end %0b, want %0b", res_ch.row_end, want.row_end));
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette dither testbench
// Loads the palette, runs directed and random pixel streams through several
// width and colour count settings with random idling on both channels, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module testbench;
	import pedd_pkg::*;

	// Palette scan plus both row sweeps.
	localparam int SETTLE_CYCLES = 2300;
	localparam int HOLD_CYCLES   = 600;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	int                        fail_count;
	int                        pending;
	bit                        calm;
	bit                        hold_req;

	pedd_in_if  pixels ();
	pedd_out_if results ();

	palette_error_diffusion_dither i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixels   (pixels.sink),
		.results  (results.source)
	);

	dither_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_ch    (pixels),
		.res_ch    (results),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial clk = 0;
	always #4 clk = ~clk;

	initial begin
		#16ms;
		$display("*** FAILED ***");
		$finish;
	end

	// Result side: random stalls, one long hold-off on request.
	initial begin
		results.ready <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				results.ready <= 0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				results.ready <= 0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				results.ready <= 1;
			end
		end
	end

	// Offer one beat and wait for it to be taken; valid stays high afterwards.
	task automatic send(input logic cmd, input logic [7:0] slot,
			input logic [7:0] r, g, b, input logic fs);
		bit taken;
		if (!calm && $urandom_range(0, 3) == 0) begin
			pixels.valid <= 0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		pixels.valid <= 1;
		pixels.command <= cmd;
		pixels.palette_slot <= slot;
		pixels.red <= r;
		pixels.green <= g;
		pixels.blue <= b;
		pixels.frame_start <= fs;
		do begin
			@(negedge clk);
			taken = pixels.ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Stop offering, wait for every result, then let the block settle.
	task automatic drain();
		pixels.valid <= 0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly pixels, with a few palette rewrites and frame starts.
	task automatic random_stream(input int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 9) == 0)
				send(CMD_PALETTE, 8'($urandom_range(0, 255)), pick_level(), pick_level(),
					pick_level(), 1'($urandom_range(0, 1)));
			else
				send(CMD_PIXEL, 8'($urandom_range(0, 255)), pick_level(), pick_level(),
					pick_level(), $urandom_range(0, 40) == 0);
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		calm = 0;
		hold_req = 0;
		pixels.valid = 0;
		pixels.command = CMD_PALETTE;
		pixels.palette_slot = '0;
		pixels.red = '0;
		pixels.green = '0;
		pixels.blue = '0;
		pixels.frame_start = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Fill the whole palette so no search ever reads an unwritten entry.
		// Slots 0 and 2 are both black to exercise the tie rule.
		for (int s = 0; s < 256; s++) begin
			case (s)
				0, 2: send(CMD_PALETTE, 8'(s), 8'd0, 8'd0, 8'd0, 1'b0);
				1: send(CMD_PALETTE, 8'(s), 8'd255, 8'd255, 8'd255, 1'b1);
				default: send(CMD_PALETTE, 8'(s), pick_level(), pick_level(), pick_level(),
					1'($urandom_range(0, 1)));
			endcase
		end
		drain();

		// Directed: extremes of the pixel fields on a small image.
		write_reg(REG_IMAGE_WIDTH, 11'd4);
		write_reg(REG_COLOUR_COUNT, 11'd3);
		send(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		send(CMD_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
		send(CMD_PIXEL, 8'd0, 8'd128, 8'd127, 8'd1, 1'b0);
		send(CMD_PIXEL, 8'd0, 8'd254, 8'd0, 8'd255, 1'b0);
		send(CMD_PIXEL, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0);
		send(CMD_PIXEL, 8'd0, 8'd0, 8'd255, 8'd0, 1'b0);
		send(CMD_PALETTE, 8'd3, 8'd128, 8'd128, 8'd128, 1'b1);
		send(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
		send(CMD_PIXEL, 8'd0, 8'd100, 8'd100, 8'd100, 1'b0);
		send(CMD_PIXEL, 8'd0, 8'd200, 8'd50, 8'd10, 1'b1);
		drain();

		// Zero width and zero count act as one.
		write_reg(REG_IMAGE_WIDTH, 11'd0);
		write_reg(REG_COLOUR_COUNT, 11'd0);
		for (int k = 0; k < 6; k++)
			send(CMD_PIXEL, 8'd0, pick_level(), pick_level(), pick_level(), k == 3);
		drain();

		// Oversize width and count clamp to the maximum.
		write_reg(REG_IMAGE_WIDTH, 11'd2047);
		write_reg(REG_COLOUR_COUNT, 11'd511);
		for (int k = 0; k < 5; k++)
			send(CMD_PIXEL, 8'd0, pick_level(), pick_level(), pick_level(), k == 0);
		drain();
		write_reg(REG_IMAGE_WIDTH, 11'd1024);
		write_reg(REG_COLOUR_COUNT, 11'd256);
		for (int k = 0; k < 5; k++)
			send(CMD_PIXEL, 8'd0, pick_level(), pick_level(), pick_level(), 1'b0);
		drain();

		// Random phases; a phase starts without a frame start, so a narrower
		// width can cut a row short.
		for (int p = 0; p < 12; p++) begin
			write_reg(REG_IMAGE_WIDTH, 11'($urandom_range(1, 12)));
			write_reg(REG_COLOUR_COUNT, 11'($urandom_range(1, 24)));
			if (p == 4)
				hold_req = 1;
			if (p >= 10)
				calm = 1;
			random_stream(90);
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
